FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define CHK_RUN(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("check failed");

// Check on every clock edge, reset included.
`define CHK_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("check failed");

`endif

FILE: rtl/clecv_pkg.sv
package clecv_pkg;
  localparam int SAMP_W    = 16;
  localparam int CH_N      = 4;
  localparam int PIX_W     = SAMP_W * CH_N;
  localparam int POS_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int FRAC_W    = 15;
  localparam int ROUND_ADD = 16384;
  localparam int FAR_TAP   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W_NEAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_MID    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_FAR    = 3'd5;

  // Position of the newest pixel and the output being issued.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] x;
  } clecv_emit_t;
endpackage

FILE: rtl/clecv_window.sv
module clecv_window import clecv_pkg::*; #(
  parameter int MAXR = 8
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [PIX_W-1:0] pix_in,
  input  clecv_emit_t      emit,
  output logic [PIX_W-1:0] lo_pix [MAXR+1],
  output logic [PIX_W-1:0] hi_pix [MAXR+1]
);
  localparam int DEPTH = 2 * MAXR + 1;
  localparam int JW    = $clog2(DEPTH);

  // Entry j holds the pixel j places before the newest one.
  logic [PIX_W-1:0] win_r [DEPTH];
  logic [POS_W-1:0] lag;
  logic [POS_W-1:0] lim;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r[0] <= pix_in;
      for (int j = 1; j < DEPTH; j++) win_r[j] <= win_r[j-1];
    end
  end

  assign lag = emit.pos - emit.x;
  assign lim = (emit.pos > POS_W'(DEPTH - 1)) ? POS_W'(DEPTH - 1) : emit.pos;

  for (genvar d = 0; d <= MAXR; d++) begin : g_tap
    logic [POS_W:0]  lo_raw;
    logic [POS_W:0]  hi_raw;
    logic [JW-1:0]   lo_idx;
    logic [JW-1:0]   hi_idx;
    always_comb begin
      // Clamp the left tap at pixel zero, the right tap at the newest pixel.
      lo_raw = {1'b0, lag} + (POS_W+1)'(d);
      if (lo_raw > {1'b0, lim}) lo_raw = {1'b0, lim};
      hi_raw = ({1'b0, lag} > (POS_W+1)'(d)) ? ({1'b0, lag} - (POS_W+1)'(d))
                                             : '0;
      if (hi_raw > (POS_W+1)'(DEPTH - 1)) hi_raw = (POS_W+1)'(DEPTH - 1);
      lo_idx = lo_raw[JW-1:0];
      hi_idx = hi_raw[JW-1:0];
    end
    assign lo_pix[d] = win_r[lo_idx];
    assign hi_pix[d] = win_r[hi_idx];
  end
endmodule

FILE: rtl/clecv_lane.sv
module clecv_lane import clecv_pkg::*; #(
  parameter int NTAP = 9
) (
  input  logic              clk,
  input  logic              en,
  input  logic              wide,
  input  logic [SAMP_W-1:0] lo  [NTAP],
  input  logic [SAMP_W-1:0] hi  [NTAP],
  input  logic [SAMP_W-1:0] wt  [NTAP],
  output logic [SAMP_W-1:0] res
);
  localparam int PAIR_W = SAMP_W + 1;
  localparam int PROD_W = PAIR_W + SAMP_W;
  localparam int ACC_W  = PROD_W + $clog2(NTAP + 1) + 1;

  logic [PAIR_W-1:0] pair_r [NTAP];
  logic [PROD_W-1:0] prod_r [NTAP];
  logic [ACC_W-1:0]  sum_r;
  logic [ACC_W-1:0]  sum_nxt;
  logic [ACC_W-1:0]  rnd;
  logic [SAMP_W-1:0] maxv;

  assign maxv = wide ? 16'hFFFF : 16'h00FF;

  always_ff @(posedge clk) begin
    if (en) begin
      // Fold the symmetric taps: centre once, others as left plus right.
      for (int d = 0; d < NTAP; d++) begin
        if (d == 0) pair_r[d] <= {1'b0, lo[d] & maxv};
        else        pair_r[d] <= {1'b0, lo[d] & maxv} + {1'b0, hi[d] & maxv};
      end
      for (int d = 0; d < NTAP; d++) prod_r[d] <= pair_r[d] * wt[d];
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int d = 0; d < NTAP; d++) sum_nxt = sum_nxt + ACC_W'(prod_r[d]);
  end

  always_comb begin
    rnd = (sum_r + ACC_W'(ROUND_ADD)) >> FRAC_W;
    res = (rnd > ACC_W'(maxv)) ? maxv : rnd[SAMP_W-1:0];
  end
endmodule

FILE: rtl/clamped_edge_line_convolver.sv
// Channel  Ports           Payload
// in       in_t*           tdata: chan0..chan3, tlast: line_end
// out      out_t*          tdata: res0..res3, tlast: final_out
// cfg      cfg_*           write enable, register index, 64-bit data
//
// One pixel per cycle in steady state; each pixel issues its outputs one a
// cycle from the window, so a line end holds the input until all are issued.
// After issue, results pass the fold, multiply, sum and output registers.
// Reset (sync, rst_n low) clears counters, pipeline valids and config registers.
// A stalled output freezes the whole pipeline and the input with it.
module clamped_edge_line_convolver import clecv_pkg::*; #(
  parameter int MAX_RADIUS = 8,
  parameter int LANES      = 4,
  parameter int MAX_LINE   = 65535
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,   // chan0, chan1, chan2, chan3
  input  logic                 in_tlast,   // line_end
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,  // res0, res1, res2, res3
  output logic                 out_tlast,  // final_out
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);
  localparam int NTAP    = MAX_RADIUS + 1;
  localparam int MAX_OUT = MAX_RADIUS + 1;
  localparam int RW      = $clog2(MAX_OUT + 1);

  // Configuration registers.
  logic [3:0]        radius_r;
  logic              wide_r;
  logic [2:0]        chans_r;
  logic [63:0]       w_near_r;
  logic [63:0]       w_mid_r;
  logic [15:0]       w_far_r;

  // Line position and issue sequencer.
  logic [POS_W-1:0]  seen_r, seen_nxt;
  logic [POS_W-1:0]  sent_r, sent_nxt;
  clecv_emit_t       emit_r, emit_nxt;
  logic              emit_end_r, emit_end_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;

  // Pipeline tags.
  logic              v1_r, v2_r, v3_r;
  logic              f1_r, f2_r, f3_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_data_r;
  logic              out_last_r;

  logic              en, issue, accept, line_end;
  logic [4:0]        r_eff;
  logic [2:0]        chans_eff;
  logic [POS_W:0]    avail;
  logic [RW-1:0]     cnt;
  logic [PIX_W-1:0]  lo_pix [NTAP];
  logic [PIX_W-1:0]  hi_pix [NTAP];
  logic [SAMP_W-1:0] wt     [NTAP];
  logic [SAMP_W-1:0] lane_res [CH_N];

  // Advance everything whenever the output register can move.
  assign en        = !out_valid_r || out_tready;
  assign issue     = en && (rem_r != '0);
  assign in_tready = en && (rem_r <= RW'(1));
  assign accept    = in_tvalid && in_tready;

  assign r_eff     = ({1'b0, radius_r} > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS)
                                                          : {1'b0, radius_r};
  assign chans_eff = (chans_r == 3'd0) ? 3'd1
                   : ({29'd0, chans_r} > LANES) ? 3'(LANES) : chans_r;
  assign line_end  = in_tlast || (seen_r >= POS_W'(MAX_LINE - 1));

  always_comb begin
    if (line_end) begin
      avail = {1'b0, seen_r} - {1'b0, sent_r} + 17'd1;
    end else if (({1'b0, sent_r} + 17'(r_eff)) <= {1'b0, seen_r}) begin
      avail = {1'b0, seen_r} - 17'(r_eff) - {1'b0, sent_r} + 17'd1;
    end else begin
      avail = '0;
    end
    cnt = (avail > 17'(MAX_OUT)) ? RW'(MAX_OUT) : avail[RW-1:0];
  end

  always_comb begin
    seen_nxt     = seen_r;
    sent_nxt     = sent_r;
    emit_nxt     = emit_r;
    emit_end_nxt = emit_end_r;
    rem_nxt      = rem_r;
    if (issue) begin
      emit_nxt.x = emit_r.x + 16'd1;
      rem_nxt    = rem_r - RW'(1);
    end
    if (accept) begin
      // Load the sequencer with this pixel's burst.
      emit_nxt.pos = seen_r;
      emit_nxt.x   = sent_r;
      emit_end_nxt = line_end;
      rem_nxt      = cnt;
      if (line_end) begin
        seen_nxt = '0;
        sent_nxt = '0;
      end else begin
        seen_nxt = seen_r + 16'd1;
        sent_nxt = sent_r + POS_W'(cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= 4'd0;
      wide_r      <= 1'b0;
      chans_r     <= 3'd1;
      w_near_r    <= 64'd32768;
      w_mid_r     <= 64'd0;
      w_far_r     <= 16'd0;
      seen_r      <= '0;
      sent_r      <= '0;
      emit_r      <= '0;
      emit_end_r  <= 1'b0;
      rem_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_RADIUS: radius_r <= cfg_wdata[3:0];
          REG_WIDE:   wide_r   <= cfg_wdata[0];
          REG_CHANS:  chans_r  <= cfg_wdata[2:0];
          REG_W_NEAR: w_near_r <= cfg_wdata;
          REG_W_MID:  w_mid_r  <= cfg_wdata;
          REG_W_FAR:  w_far_r  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      seen_r     <= seen_nxt;
      sent_r     <= sent_nxt;
      emit_r     <= emit_nxt;
      emit_end_r <= emit_end_nxt;
      rem_r      <= rem_nxt;
      if (en) begin
        v1_r        <= issue;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        out_valid_r <= v3_r;
      end
    end
  end

  // Tags and merged result need no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r       <= emit_end_r && (emit_r.x == emit_r.pos);
      f2_r       <= f1_r;
      f3_r       <= f2_r;
      out_last_r <= f3_r;
      for (int c = 0; c < CH_N; c++) begin
        out_data_r[c*SAMP_W +: SAMP_W] <= (c < chans_eff) ? lane_res[c] : '0;
      end
    end
  end

  // Tap weights: zero beyond the radius and beyond the far tap.
  for (genvar d = 0; d < NTAP; d++) begin : g_wt
    logic [SAMP_W-1:0] w_raw;
    if (d < 4) begin : g_near
      assign w_raw = w_near_r[d*SAMP_W +: SAMP_W];
    end else if (d < 8) begin : g_mid
      assign w_raw = w_mid_r[(d-4)*SAMP_W +: SAMP_W];
    end else if (d == FAR_TAP) begin : g_far
      assign w_raw = w_far_r;
    end else begin : g_none
      assign w_raw = '0;
    end
    assign wt[d] = (5'(d) <= r_eff) ? w_raw : '0;
  end

  clecv_window #(.MAXR(MAX_RADIUS)) u_window (
    .clk      (clk),
    .shift_en (accept),
    .pix_in   (in_tdata),
    .emit     (emit_r),
    .lo_pix   (lo_pix),
    .hi_pix   (hi_pix)
  );

  for (genvar c = 0; c < CH_N; c++) begin : g_lane
    if (c < LANES) begin : g_on
      logic [SAMP_W-1:0] lo_s [NTAP];
      logic [SAMP_W-1:0] hi_s [NTAP];
      for (genvar d = 0; d < NTAP; d++) begin : g_sl
        assign lo_s[d] = lo_pix[d][c*SAMP_W +: SAMP_W];
        assign hi_s[d] = hi_pix[d][c*SAMP_W +: SAMP_W];
      end
      clecv_lane #(.NTAP(NTAP)) u_lane (
        .clk  (clk),
        .en   (en),
        .wide (wide_r),
        .lo   (lo_s),
        .hi   (hi_s),
        .wt   (wt),
        .res  (lane_res[c])
      );
    end else begin : g_off
      assign lane_res[c] = '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
endmodule

FILE: rtl/clecv_checker.sv
`include "assert_macros.svh"
module clecv_checker import clecv_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [PIX_W-1:0] out_tdata,
  input logic             out_tlast
);
  // A stalled result beat holds.
  `CHK_RUN(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // The input is held off while the output is stalled.
  `CHK_RUN(a_stall_blocks_in, clk, rst_n, out_tvalid && !out_tready |-> !in_tready)
  // Reset empties the output.
  `CHK_ALL(a_reset_empty, clk, $past(rst_n) == 1'b0 |-> !out_tvalid)
endmodule

bind clamped_edge_line_convolver clecv_checker u_clecv_checker (.*);
